// ===== src/ilim_pkg.sv =====
`timescale 1ns / 1ps

package ilim_pkg;

  localparam logic [2:0] CmdEdge   = 3'd0;
  localparam logic [2:0] CmdWake   = 3'd1;
  localparam logic [2:0] CmdIdle   = 3'd2;
  localparam logic [2:0] CmdReport = 3'd3;
  localparam logic [2:0] CmdFinish = 3'd4;

  localparam logic WhichBurst = 1'b0;
  localparam logic WhichTotal = 1'b1;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    OpEdge   = 3'd0,
    OpWake   = 3'd1,
    OpIdle   = 3'd2,
    OpReport = 3'd3,
    OpFinish = 3'd4
  } op_e;

  localparam int unsigned OpBits = $bits(op_e);

endpackage

// ===== src/ilim_front.sv =====
`timescale 1ns / 1ps

module ilim_front import ilim_pkg::*; #(
  parameter int unsigned TIME_BITS = 64
) (
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [2:0]           cmd_i,
  input  logic [TIME_BITS-1:0] timestamp_i,
  output logic                 push_o,
  output op_e                  op_o,
  output logic [TIME_BITS-1:0] ts_o
);

  logic legal;

  // Unused command codes are accepted and dropped here.
  always_comb begin
    legal = 1'b1;
    op_o  = OpEdge;
    unique case (cmd_i)
      CmdEdge:   op_o = OpEdge;
      CmdWake:   op_o = OpWake;
      CmdIdle:   op_o = OpIdle;
      CmdReport: op_o = OpReport;
      CmdFinish: op_o = OpFinish;
      default:   legal = 1'b0;
    endcase
  end

  assign push_o = in_valid_i & in_ready_i & legal;
  assign ts_o   = timestamp_i;

endmodule

// ===== src/ilim_queue.sv =====
`timescale 1ns / 1ps

module ilim_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             not_full_o,
  input  logic             pop_i,
  output logic             not_empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntBits = $clog2(Depth + 1);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  assign not_full_o  = (count_q != CntBits'(Depth));
  assign not_empty_o = (count_q != '0);
  assign data_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(Depth - 1)) ? '0 : wr_ptr_q + PtrBits'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(Depth - 1)) ? '0 : rd_ptr_q + PtrBits'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntBits'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== src/ilim_back.sv =====
`timescale 1ns / 1ps

module ilim_back import ilim_pkg::*; #(
  parameter int unsigned TIME_BITS  = 64,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  head_valid_i,
  input  op_e                   head_op_i,
  input  logic [TIME_BITS-1:0]  head_ts_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  which_set_o,
  output logic [COUNT_BITS-1:0] edge_count_o,
  output logic [COUNT_BITS-1:0] service_count_o,
  output logic [COUNT_BITS-1:0] skipped_count_o,
  output logic [TIME_BITS-1:0]  latency_sum_o,
  output logic [TIME_BITS-1:0]  latency_min_o,
  output logic [TIME_BITS-1:0]  latency_max_o,
  output logic [TIME_BITS-1:0]  gap_sum_o,
  output logic [TIME_BITS-1:0]  gap_min_o,
  output logic [TIME_BITS-1:0]  gap_max_o,
  output logic                  last_o
);

  localparam int unsigned TW = TIME_BITS;
  localparam int unsigned CW = COUNT_BITS;

  typedef struct packed {
    logic [CW-1:0] edges;
    logic [CW-1:0] wakes;
    logic [CW-1:0] skipped;
    logic [TW-1:0] lat_sum;
    logic [TW-1:0] lat_min;
    logic [TW-1:0] lat_max;
    logic [TW-1:0] gap_sum;
    logic [TW-1:0] gap_min;
    logic [TW-1:0] gap_max;
  } set_t;

  localparam set_t SetReset = '{
    edges:   '0,
    wakes:   '0,
    skipped: '0,
    lat_sum: '0,
    lat_min: '1,
    lat_max: '0,
    gap_sum: '0,
    gap_min: '1,
    gap_max: '0
  };

  function automatic set_t merge_set(set_t tot, set_t bur);
    set_t r;
    r         = tot;
    r.edges   = tot.edges + bur.edges;
    r.wakes   = tot.wakes + bur.wakes;
    r.skipped = tot.skipped + bur.skipped;
    r.lat_sum = tot.lat_sum + bur.lat_sum;
    r.gap_sum = tot.gap_sum + bur.gap_sum;
    if (bur.lat_min < tot.lat_min) r.lat_min = bur.lat_min;
    if (bur.lat_max > tot.lat_max) r.lat_max = bur.lat_max;
    if (bur.gap_min < tot.gap_min) r.gap_min = bur.gap_min;
    if (bur.gap_max > tot.gap_max) r.gap_max = bur.gap_max;
    return r;
  endfunction

  logic [CW-1:0] edge_seq_q, edge_seq_d, served_seq_q, served_seq_d;
  logic [TW-1:0] last_edge_q, last_edge_d, prev_edge_q, prev_edge_d;
  logic          prev_valid_q, prev_valid_d;
  logic          phase_q, phase_d;
  set_t          burst_q, burst_d, total_q, total_d;

  logic          out_valid_q, out_valid_d;
  logic          out_which_q, out_which_d, out_last_q, out_last_d;
  set_t          out_set_q, out_set_d;
  logic          load_out;

  logic          burst_live, two_beat, needs_out, can_out, fire;
  logic [TW-1:0] gap, lat;
  logic [CW-1:0] next_seq;

  assign burst_live = (burst_q.edges != '0);
  assign two_beat   = (head_op_i == OpReport) || ((head_op_i == OpFinish) && burst_live);
  assign needs_out  = (head_op_i == OpReport) || (head_op_i == OpFinish) ||
                      ((head_op_i == OpIdle) && burst_live);
  assign can_out    = !out_valid_q || out_ready_i;
  assign fire       = head_valid_i && (!needs_out || can_out);
  assign pop_o      = fire && (!two_beat || phase_q);

  assign gap      = head_ts_i - prev_edge_q;
  assign lat      = head_ts_i - last_edge_q;
  assign next_seq = served_seq_q + CW'(1);

  always_comb begin
    edge_seq_d   = edge_seq_q;
    served_seq_d = served_seq_q;
    last_edge_d  = last_edge_q;
    prev_edge_d  = prev_edge_q;
    prev_valid_d = prev_valid_q;
    phase_d      = phase_q;
    burst_d      = burst_q;
    total_d      = total_q;
    load_out     = 1'b0;
    out_set_d    = burst_q;
    out_which_d  = WhichBurst;
    out_last_d   = 1'b1;

    if (fire) begin
      if (two_beat) begin
        phase_d = !phase_q;
      end
      unique case (head_op_i)
        OpEdge: begin
          edge_seq_d    = edge_seq_q + CW'(1);
          last_edge_d   = head_ts_i;
          burst_d.edges = burst_q.edges + CW'(1);
          if (prev_valid_q) begin
            burst_d.gap_sum = burst_q.gap_sum + gap;
            if (gap < burst_q.gap_min) burst_d.gap_min = gap;
            if (gap > burst_q.gap_max) burst_d.gap_max = gap;
          end
          prev_edge_d  = head_ts_i;
          prev_valid_d = 1'b1;
        end
        OpWake: begin
          if (edge_seq_q > next_seq) begin
            burst_d.skipped = burst_q.skipped + (edge_seq_q - next_seq);
          end
          burst_d.wakes   = burst_q.wakes + CW'(1);
          burst_d.lat_sum = burst_q.lat_sum + lat;
          if (lat < burst_q.lat_min) burst_d.lat_min = lat;
          if (lat > burst_q.lat_max) burst_d.lat_max = lat;
          served_seq_d = edge_seq_q;
        end
        OpIdle: begin
          if (burst_live) begin
            load_out     = 1'b1;
            total_d      = merge_set(total_q, burst_q);
            burst_d      = SetReset;
            prev_valid_d = 1'b0;
            prev_edge_d  = '0;
          end
        end
        OpReport: begin
          load_out = 1'b1;
          if (phase_q) begin
            out_set_d   = total_q;
            out_which_d = WhichTotal;
          end else begin
            out_last_d = 1'b0;
          end
        end
        OpFinish: begin
          load_out = 1'b1;
          if (two_beat && !phase_q) begin
            out_last_d = 1'b0;
            total_d    = merge_set(total_q, burst_q);
          end else begin
            out_set_d    = total_q;
            out_which_d  = WhichTotal;
            edge_seq_d   = '0;
            served_seq_d = '0;
            last_edge_d  = '0;
            prev_edge_d  = '0;
            prev_valid_d = 1'b0;
            burst_d      = SetReset;
            total_d      = SetReset;
          end
        end
        default: ;
      endcase
    end

    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_seq_q   <= '0;
      served_seq_q <= '0;
      last_edge_q  <= '0;
      prev_edge_q  <= '0;
      prev_valid_q <= 1'b0;
      phase_q      <= 1'b0;
      burst_q      <= SetReset;
      total_q      <= SetReset;
      out_valid_q  <= 1'b0;
    end else begin
      edge_seq_q   <= edge_seq_d;
      served_seq_q <= served_seq_d;
      last_edge_q  <= last_edge_d;
      prev_edge_q  <= prev_edge_d;
      prev_valid_q <= prev_valid_d;
      phase_q      <= phase_d;
      burst_q      <= burst_d;
      total_q      <= total_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_set_q   <= out_set_d;
      out_which_q <= out_which_d;
      out_last_q  <= out_last_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign which_set_o     = out_which_q;
  assign last_o          = out_last_q;
  assign edge_count_o    = out_set_q.edges;
  assign service_count_o = out_set_q.wakes;
  assign skipped_count_o = out_set_q.skipped;
  assign latency_sum_o   = out_set_q.lat_sum;
  assign latency_min_o   = out_set_q.lat_min;
  assign latency_max_o   = out_set_q.lat_max;
  assign gap_sum_o       = out_set_q.gap_sum;
  assign gap_min_o       = out_set_q.gap_min;
  assign gap_max_o       = out_set_q.gap_max;

endmodule

// ===== src/irq_latency_interval_monitor.sv =====
// A two-entry queue decouples intake from the statistics engine, which takes beats from its head; a
// result beat is registered in the cycle after the engine takes its command beat. Throughput: one
// command beat per cycle while the queue is not full; report, and finish with a live burst, give
// two result beats and hold the queue head until the second is loaded.
// Reset (asynchronous, active low): queue empty, counters and sums zero, minima all ones.
`timescale 1ns / 1ps

module irq_latency_interval_monitor import ilim_pkg::*; #(
  parameter int unsigned TIME_BITS  = 64,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            cmd_i,
  input  logic [TIME_BITS-1:0]  timestamp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  which_set_o,
  output logic [COUNT_BITS-1:0] edge_count_o,
  output logic [COUNT_BITS-1:0] service_count_o,
  output logic [COUNT_BITS-1:0] skipped_count_o,
  output logic [TIME_BITS-1:0]  latency_sum_o,
  output logic [TIME_BITS-1:0]  latency_min_o,
  output logic [TIME_BITS-1:0]  latency_max_o,
  output logic [TIME_BITS-1:0]  gap_sum_o,
  output logic [TIME_BITS-1:0]  gap_min_o,
  output logic [TIME_BITS-1:0]  gap_max_o,
  output logic                  last_o
);

  localparam int unsigned EntryBits = OpBits + TIME_BITS;

  logic                 push, pop, not_full, head_valid;
  op_e                  push_op;
  logic [TIME_BITS-1:0] push_ts;
  logic [EntryBits-1:0] head;

  assign in_ready_o = not_full;

  ilim_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_i (not_full),
    .cmd_i      (cmd_i),
    .timestamp_i(timestamp_i),
    .push_o     (push),
    .op_o       (push_op),
    .ts_o       (push_ts)
  );

  ilim_queue #(
    .Width(EntryBits),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .data_i     ({push_op, push_ts}),
    .not_full_o (not_full),
    .pop_i      (pop),
    .not_empty_o(head_valid),
    .data_o     (head)
  );

  ilim_back #(
    .TIME_BITS (TIME_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_op_i      (op_e'(head[EntryBits-1:TIME_BITS])),
    .head_ts_i      (head[TIME_BITS-1:0]),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .which_set_o    (which_set_o),
    .edge_count_o   (edge_count_o),
    .service_count_o(service_count_o),
    .skipped_count_o(skipped_count_o),
    .latency_sum_o  (latency_sum_o),
    .latency_min_o  (latency_min_o),
    .latency_max_o  (latency_max_o),
    .gap_sum_o      (gap_sum_o),
    .gap_min_o      (gap_min_o),
    .gap_max_o      (gap_max_o),
    .last_o         (last_o)
  );

endmodule
